// ===== rtl/gvfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfr_pkg
// Shared constants, codes, the controller/datapath command and status structs
// and the arctangent table of the rotator.
// ----------------------------------------------------------------------------
package gvfr_pkg;

  // event codes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMMAND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SPIN    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_YAW     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PLAN    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SYNCED  = 3'd7;

  // drive status codes
  localparam int DRIVE_W = 2;
  localparam logic [DRIVE_W-1:0] DRIVE_HALTED = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_FOLLOW = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_SPIN   = 2'd2;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_TIMEOUT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_TIMEOUT  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANNER_TIMEOUT = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SPIN    = 8'd3;

  localparam logic [CFG_DATA_W-1:0] COMMAND_TIMEOUT_RST = 16'd300;
  localparam logic [CFG_DATA_W-1:0] STATUS_TIMEOUT_RST  = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] PLANNER_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] INITIAL_SPIN_RST    = 16'd0;

  // cordic: angles in 2^32 per turn, vectors in Q1.30
  localparam int CORDIC_STEPS = 30;
  localparam int ITER_W       = 5;
  localparam int ATAN_W       = 31;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;
  localparam int CS_W         = 32;
  localparam int FRAC         = 30;
  localparam int PHASE_W      = 3;
  localparam logic [XY_W-1:0] CORDIC_GAIN = 34'd652032874;

  // controller to datapath
  typedef struct packed {
    logic               accept;
    logic               eval;
    logic               cordic_step;
    logic [ITER_W-1:0]  iter;
    logic               quad;
    logic               mac_step;
    logic [PHASE_W-1:0] phase;
    logic               finish;
    logic               load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_publish;
    logic follow;
  } dp_sts_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 31'd536870912;
      5'd1:  v = 31'd316933406;
      5'd2:  v = 31'd167458907;
      5'd3:  v = 31'd85004756;
      5'd4:  v = 31'd42667331;
      5'd5:  v = 31'd21354465;
      5'd6:  v = 31'd10679838;
      5'd7:  v = 31'd5340245;
      5'd8:  v = 31'd2670163;
      5'd9:  v = 31'd1335087;
      5'd10: v = 31'd667544;
      5'd11: v = 31'd333772;
      5'd12: v = 31'd166886;
      5'd13: v = 31'd83443;
      5'd14: v = 31'd41722;
      5'd15: v = 31'd20861;
      5'd16: v = 31'd10430;
      5'd17: v = 31'd5215;
      5'd18: v = 31'd2608;
      5'd19: v = 31'd1304;
      5'd20: v = 31'd652;
      5'd21: v = 31'd326;
      5'd22: v = 31'd163;
      5'd23: v = 31'd81;
      5'd24: v = 31'd41;
      5'd25: v = 31'd20;
      5'd26: v = 31'd10;
      5'd27: v = 31'd5;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gvfr_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfr_item_if
// Event channel: valid/ready handshake with one event word.
// ----------------------------------------------------------------------------
interface gvfr_item_if #(
  parameter int VEL_BITS   = 16,
  parameter int ANGLE_BITS = 16
);
  import gvfr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [MODE_W-1:0]            mode;
  logic signed [VEL_BITS-1:0]   vel_x;
  logic signed [VEL_BITS-1:0]   vel_y;
  logic signed [VEL_BITS-1:0]   turn_rate;
  logic [ANGLE_BITS-1:0]        yaw_angle;
  logic                         flag;

  modport source (output valid, mode, vel_x, vel_y, turn_rate, yaw_angle, flag,
                  input ready);
  modport sink   (input valid, mode, vel_x, vel_y, turn_rate, yaw_angle, flag,
                  output ready);
endinterface

// ===== rtl/gvfr_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfr_result_if
// Result channel: valid/ready handshake with one drive word.
// ----------------------------------------------------------------------------
interface gvfr_result_if #(
  parameter int VEL_BITS   = 16,
  parameter int ANGLE_BITS = 16
);
  import gvfr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VEL_BITS-1:0]   out_vel_x;
  logic signed [VEL_BITS-1:0]   out_vel_y;
  logic signed [VEL_BITS-1:0]   out_turn_rate;
  logic [ANGLE_BITS-1:0]        frame_angle;
  logic [DRIVE_W-1:0]           drive_status;

  modport source (output valid, out_vel_x, out_vel_y, out_turn_rate, frame_angle,
                  drive_status, input ready);
  modport sink   (input valid, out_vel_x, out_vel_y, out_turn_rate, frame_angle,
                  drive_status, output ready);
endinterface

// ===== rtl/gvfr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfr_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface gvfr_cfg_if;
  import gvfr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gvfr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfr_datapath
// Event state, gating decision, shared cordic stage, shared multiplier and
// result/output registers.
// ----------------------------------------------------------------------------
module gvfr_datapath #(
  parameter int AGE_BITS   = 16,
  parameter int VEL_BITS   = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gvfr_pkg::dp_cmd_t                 cmd,
  output gvfr_pkg::dp_sts_t                 sts,
  input  logic [gvfr_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [VEL_BITS-1:0]        in_vel_x,
  input  logic signed [VEL_BITS-1:0]        in_vel_y,
  input  logic signed [VEL_BITS-1:0]        in_turn_rate,
  input  logic [ANGLE_BITS-1:0]             in_yaw_angle,
  input  logic                              in_flag,
  input  logic                              cfg_we,
  input  logic [gvfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gvfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic signed [VEL_BITS-1:0]        out_vel_x,
  output logic signed [VEL_BITS-1:0]        out_vel_y,
  output logic signed [VEL_BITS-1:0]        out_turn_rate,
  output logic [ANGLE_BITS-1:0]             frame_angle,
  output logic [gvfr_pkg::DRIVE_W-1:0]      drive_status
);
  import gvfr_pkg::*;

  localparam int CMP_W  = (AGE_BITS > CFG_DATA_W) ? AGE_BITS : CFG_DATA_W;
  localparam int SUM_W  = ((VEL_BITS > CFG_DATA_W) ? VEL_BITS : CFG_DATA_W) + 1;
  localparam int PROD_W = VEL_BITS + CS_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - FRAC;
  localparam int ANG32_PAD = 32 - ANGLE_BITS;

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    SUM_W'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
  localparam logic signed [RND_W-1:0] RND_MAX =
    RND_W'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] RND_MIN = -RND_MAX - RND_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC - 1));
  localparam logic [AGE_BITS-1:0]     AGE_SAT  = '1;

  // configuration registers
  logic [CFG_DATA_W-1:0]        command_timeout;
  logic [CFG_DATA_W-1:0]        status_timeout;
  logic [CFG_DATA_W-1:0]        planner_timeout;
  logic signed [CFG_DATA_W-1:0] initial_spin;

  // event state
  logic [AGE_BITS-1:0]          command_age;
  logic [AGE_BITS-1:0]          status_age;
  logic [AGE_BITS-1:0]          planner_age;
  logic                         status_seen;
  logic                         run_enabled;
  logic                         stop_active;
  logic                         command_held;
  logic signed [VEL_BITS-1:0]   held_x;
  logic signed [VEL_BITS-1:0]   held_y;
  logic signed [VEL_BITS-1:0]   held_rate;
  logic                         spin_seen;
  logic signed [VEL_BITS-1:0]   spin_rate;
  logic [ANGLE_BITS-1:0]        body_yaw;

  // arithmetic registers
  logic signed [XY_W-1:0]       cx;
  logic signed [XY_W-1:0]       cy;
  logic signed [Z_W-1:0]        cz;
  logic [1:0]                   quadrant;
  logic signed [CS_W-1:0]       cos_v;
  logic signed [CS_W-1:0]       sin_v;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc_x;
  logic signed [ACC_W-1:0]      acc_y;
  logic signed [VEL_BITS-1:0]   res_x;
  logic signed [VEL_BITS-1:0]   res_y;
  logic signed [VEL_BITS-1:0]   res_rate;
  logic [DRIVE_W-1:0]           res_status;

  // gating
  logic                         status_fresh;
  logic                         allowed;
  logic                         cmd_usable;
  logic                         follow;
  logic                         cmd_zero;
  logic                         planner_idle;

  assign status_fresh = status_seen &&
                        (CMP_W'(status_age) <= CMP_W'(status_timeout));
  assign allowed      = status_fresh && run_enabled && !stop_active;
  assign cmd_usable   = command_held &&
                        (CMP_W'(command_age) <= CMP_W'(command_timeout));
  assign follow       = allowed && cmd_usable;
  assign cmd_zero     = (in_vel_x == '0) && (in_vel_y == '0) && (in_turn_rate == '0);
  assign planner_idle = CMP_W'(planner_age) > CMP_W'(planner_timeout);

  assign sts.is_publish = (in_mode == MODE_TICK) && in_flag;
  assign sts.follow     = follow;

  // turn rate sum and saturation
  logic signed [SUM_W-1:0] spin_ext;
  logic signed [SUM_W-1:0] rate_sum;
  logic signed [VEL_BITS-1:0] rate_sat;

  always_comb begin
    spin_ext = spin_seen ? SUM_W'(spin_rate) : SUM_W'(initial_spin);
    rate_sum = follow ? (SUM_W'(held_rate) + spin_ext) : spin_ext;
    if (rate_sum > SUM_MAX) begin
      rate_sat = VEL_BITS'(SUM_MAX);
    end else if (rate_sum < SUM_MIN) begin
      rate_sat = VEL_BITS'(SUM_MIN);
    end else begin
      rate_sat = VEL_BITS'(rate_sum);
    end
  end

  // quadrant reduction of the stored yaw
  logic [31:0]            ang32;
  logic [31:0]            ang_round;
  logic [1:0]             quad0;
  logic [31:0]            ang_res;

  always_comb begin
    ang32     = {body_yaw, {ANG32_PAD{1'b0}}};
    ang_round = ang32 + 32'h2000_0000;
    quad0     = ang_round[31:30];
    ang_res   = ang32 - {quad0, 30'd0};
  end

  // one cordic micro-rotation
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  atan_step;

  always_comb begin
    dx        = cy >>> cmd.iter;
    dy        = cx >>> cmd.iter;
    atan_step = $signed({2'b00, atan_lut(cmd.iter)});
  end

  // quadrant correction
  logic signed [XY_W-1:0] cos_q;
  logic signed [XY_W-1:0] sin_q;

  always_comb begin
    case (quadrant)
      2'd0: begin
        cos_q = cx;
        sin_q = cy;
      end
      2'd1: begin
        cos_q = -cy;
        sin_q = cx;
      end
      2'd2: begin
        cos_q = -cx;
        sin_q = -cy;
      end
      default: begin
        cos_q = cy;
        sin_q = -cx;
      end
    endcase
  end

  // multiplier operand select: x*c, y*s, y*c, x*s
  logic signed [VEL_BITS-1:0] mul_a;
  logic signed [CS_W-1:0]     mul_b;

  always_comb begin
    mul_a = (cmd.phase == 3'd1 || cmd.phase == 3'd2) ? held_y : held_x;
    mul_b = (cmd.phase == 3'd1 || cmd.phase == 3'd3) ? sin_v : cos_v;
  end

  // rounding and saturation of the rotated pair
  logic signed [ACC_W-1:0] rnd_x_sum;
  logic signed [ACC_W-1:0] rnd_y_sum;
  logic signed [RND_W-1:0] rnd_x;
  logic signed [RND_W-1:0] rnd_y;
  logic signed [VEL_BITS-1:0] sat_x;
  logic signed [VEL_BITS-1:0] sat_y;

  always_comb begin
    rnd_x_sum = acc_x + RND_HALF;
    rnd_y_sum = acc_y + RND_HALF;
    rnd_x     = $signed(rnd_x_sum[ACC_W-1:FRAC]);
    rnd_y     = $signed(rnd_y_sum[ACC_W-1:FRAC]);
    if (rnd_x > RND_MAX) begin
      sat_x = VEL_BITS'(RND_MAX);
    end else if (rnd_x < RND_MIN) begin
      sat_x = VEL_BITS'(RND_MIN);
    end else begin
      sat_x = VEL_BITS'(rnd_x);
    end
    if (rnd_y > RND_MAX) begin
      sat_y = VEL_BITS'(RND_MAX);
    end else if (rnd_y < RND_MIN) begin
      sat_y = VEL_BITS'(RND_MIN);
    end else begin
      sat_y = VEL_BITS'(rnd_y);
    end
  end

  // configuration and event state
  always_ff @(posedge clk) begin
    if (rst) begin
      command_timeout <= COMMAND_TIMEOUT_RST;
      status_timeout  <= STATUS_TIMEOUT_RST;
      planner_timeout <= PLANNER_TIMEOUT_RST;
      initial_spin    <= INITIAL_SPIN_RST;
      command_age     <= AGE_SAT;
      status_age      <= AGE_SAT;
      planner_age     <= AGE_SAT;
      status_seen     <= 1'b0;
      run_enabled     <= 1'b0;
      stop_active     <= 1'b0;
      command_held    <= 1'b0;
      held_x          <= '0;
      held_y          <= '0;
      held_rate       <= '0;
      spin_seen       <= 1'b0;
      spin_rate       <= '0;
      body_yaw        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMMAND_TIMEOUT: command_timeout <= cfg_data;
          CFG_STATUS_TIMEOUT:  status_timeout  <= cfg_data;
          CFG_PLANNER_TIMEOUT: planner_timeout <= cfg_data;
          CFG_INITIAL_SPIN:    initial_spin    <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (in_mode)
          MODE_TICK: begin
            if (command_age != AGE_SAT) command_age <= command_age + AGE_BITS'(1);
            if (status_age != AGE_SAT)  status_age  <= status_age + AGE_BITS'(1);
            if (planner_age != AGE_SAT) planner_age <= planner_age + AGE_BITS'(1);
          end
          MODE_COMMAND: begin
            if (cmd_zero || !allowed) begin
              command_held <= 1'b0;
              held_x       <= '0;
              held_y       <= '0;
              held_rate    <= '0;
            end else begin
              command_held <= 1'b1;
              held_x       <= in_vel_x;
              held_y       <= in_vel_y;
              held_rate    <= in_turn_rate;
              command_age  <= '0;
            end
          end
          MODE_STATUS: begin
            status_seen <= 1'b1;
            status_age  <= '0;
            run_enabled <= in_flag;
            if (!in_flag) begin
              command_held <= 1'b0;
              held_x       <= '0;
              held_y       <= '0;
              held_rate    <= '0;
            end
          end
          MODE_STOP: begin
            stop_active <= in_flag;
            if (in_flag) begin
              command_held <= 1'b0;
              held_x       <= '0;
              held_y       <= '0;
              held_rate    <= '0;
            end
          end
          MODE_SPIN: begin
            spin_seen <= 1'b1;
            spin_rate <= in_turn_rate;
          end
          MODE_YAW: begin
            if (planner_idle) body_yaw <= in_yaw_angle;
          end
          MODE_PLAN: begin
            planner_age <= '0;
          end
          MODE_SYNCED: begin
            body_yaw <= in_yaw_angle;
          end
          default: ;
        endcase
      end
      // publish without a usable command drops what is held
      if (cmd.eval && !follow) begin
        command_held <= 1'b0;
        held_x       <= '0;
        held_y       <= '0;
        held_rate    <= '0;
      end
    end
  end

  // rotation and result registers
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cx         <= $signed(CORDIC_GAIN);
      cy         <= '0;
      cz         <= $signed({ang_res[31], ang_res});
      quadrant   <= quad0;
      res_x      <= '0;
      res_y      <= '0;
      res_rate   <= allowed ? rate_sat : '0;
      res_status <= follow ? DRIVE_FOLLOW : (allowed ? DRIVE_SPIN : DRIVE_HALTED);
    end
    if (cmd.cordic_step) begin
      if (!cz[Z_W-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_step;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_step;
      end
    end
    if (cmd.quad) begin
      cos_v <= CS_W'(cos_q);
      sin_v <= CS_W'(sin_q);
    end
    if (cmd.mac_step) begin
      if (cmd.phase != 3'd4) prod <= mul_a * mul_b;
      case (cmd.phase)
        3'd1: acc_x <= ACC_W'(prod);
        3'd2: acc_x <= acc_x + ACC_W'(prod);
        3'd3: acc_y <= ACC_W'(prod);
        3'd4: acc_y <= acc_y - ACC_W'(prod);
        default: ;
      endcase
    end
    if (cmd.finish) begin
      res_x <= sat_x;
      res_y <= sat_y;
    end
    if (cmd.load_out) begin
      out_vel_x     <= res_x;
      out_vel_y     <= res_y;
      out_turn_rate <= res_rate;
      frame_angle   <= ANGLE_BITS'(0) - body_yaw;
      drive_status  <= res_status;
    end
  end

endmodule

// ===== rtl/gvfr_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvfr_controller
// Sequencer for event intake, publish evaluation, cordic iterations,
// multiply-accumulate phases and the output register handshake.
// ----------------------------------------------------------------------------
module gvfr_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gvfr_pkg::dp_sts_t sts,
  output gvfr_pkg::dp_cmd_t cmd
);
  import gvfr_pkg::*;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] S_EVAL = 3'd1;
  localparam logic [STATE_W-1:0] S_ROT  = 3'd2;
  localparam logic [STATE_W-1:0] S_QUAD = 3'd3;
  localparam logic [STATE_W-1:0] S_MAC  = 3'd4;
  localparam logic [STATE_W-1:0] S_FIN  = 3'd5;
  localparam logic [STATE_W-1:0] S_OUT  = 3'd6;

  localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
  localparam logic [PHASE_W-1:0] MAC_LAST  = 3'd4;

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;
  logic [ITER_W-1:0]  iter;
  logic [ITER_W-1:0]  iter_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic               out_valid_next;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    iter_next  = iter;
    phase_next = phase;
    cmd        = '0;
    cmd.iter   = iter;
    cmd.phase  = phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_publish) state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        iter_next = '0;
        state_next = sts.follow ? S_ROT : S_OUT;
      end
      S_ROT: begin
        cmd.cordic_step = 1'b1;
        if (iter == ITER_LAST) begin
          state_next = S_QUAD;
        end else begin
          iter_next = iter + ITER_W'(1);
        end
      end
      S_QUAD: begin
        cmd.quad   = 1'b1;
        phase_next = '0;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (phase == MAC_LAST) begin
          state_next = S_FIN;
        end else begin
          phase_next = phase + PHASE_W'(1);
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/gated_velocity_frame_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_velocity_frame_rotator
// Gated velocity command rotator: keeps tick ages, a held command and enable
// flags, and on a publish tick emits the yaw-rotated command plus spin.
// ----------------------------------------------------------------------------
// Every event other than a publish tick is taken back to back, one per cycle.
// A publish tick that ends halted or spin-only stalls the input while the
// block evaluates and then loads the output register. One that follows the
// held command stalls the input longer: it also runs the 30-step cordic (one
// shift-add micro-rotation per cycle), a quadrant correction step, the
// multiply-accumulate phases on the single VEL_BITS by 32-bit multiplier used
// four times for the rotation, and a rounding step. The result sits in an
// output register, so events keep flowing while it waits to be taken; only
// the next publish waits, in its output-load state, for the slot to free.
// Configuration writes are always ready and take effect the next cycle.
module gated_velocity_frame_rotator #(
  parameter int AGE_BITS   = 16,
  parameter int VEL_BITS   = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  gvfr_item_if.sink        item,
  gvfr_result_if.source    result,
  gvfr_cfg_if.sink         cfg
);
  import gvfr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // configuration writes are never stalled
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  gvfr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gvfr_datapath #(
    .AGE_BITS   (AGE_BITS),
    .VEL_BITS   (VEL_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (item.mode),
    .in_vel_x      (item.vel_x),
    .in_vel_y      (item.vel_y),
    .in_turn_rate  (item.turn_rate),
    .in_yaw_angle  (item.yaw_angle),
    .in_flag       (item.flag),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_vel_x     (result.out_vel_x),
    .out_vel_y     (result.out_vel_y),
    .out_turn_rate (result.out_turn_rate),
    .frame_angle   (result.frame_angle),
    .drive_status  (result.drive_status)
  );

endmodule

// ===== dv/gated_velocity_frame_rotator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_velocity_frame_rotator_tb
// Self-checking bench for the gated velocity frame rotator. A queue of events
// feeds a negedge driver; a posedge monitor runs every accepted event through
// a local model of the gating, ages and cordic rotation, and checks each
// drive word in order. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module gated_velocity_frame_rotator_tb;
  import gvfr_pkg::*;

  localparam int AGE_BITS   = 16;
  localparam int VEL_BITS   = 16;
  localparam int ANGLE_BITS = 16;

  localparam int  SETTLE_CYCLES = 60;
  localparam int  QUIET_LIMIT   = 4000;
  localparam int  SHOW_LIMIT    = 10;
  localparam int  PHASE_EVENTS  = 105;
  localparam logic [AGE_BITS-1:0]    AGE_SAT         = '1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SPARE = 8'd4;

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic signed [VEL_BITS-1:0]   vel_x;
    logic signed [VEL_BITS-1:0]   vel_y;
    logic signed [VEL_BITS-1:0]   turn_rate;
    logic [ANGLE_BITS-1:0]        yaw_angle;
    logic                         flag;
  } event_t;

  typedef struct packed {
    logic signed [VEL_BITS-1:0]   vel_x;
    logic signed [VEL_BITS-1:0]   vel_y;
    logic signed [VEL_BITS-1:0]   turn_rate;
    logic [ANGLE_BITS-1:0]        frame_angle;
    logic [DRIVE_W-1:0]           drive_status;
  } drive_t;

  logic clk;
  logic rst;

  gvfr_item_if #(.VEL_BITS(VEL_BITS), .ANGLE_BITS(ANGLE_BITS)) ev_ch ();
  gvfr_result_if #(.VEL_BITS(VEL_BITS), .ANGLE_BITS(ANGLE_BITS)) drive_ch ();
  gvfr_cfg_if reg_ch ();

  gated_velocity_frame_rotator #(
    .AGE_BITS   (AGE_BITS),
    .VEL_BITS   (VEL_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (ev_ch),
    .result (drive_ch),
    .cfg    (reg_ch)
  );

  // stimulus and expectation stores
  event_t event_feed[$];
  drive_t drive_due[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          event_taken;

  int unsigned errors;
  int unsigned shown;
  int unsigned events_accepted;
  int unsigned regs_written;
  int unsigned settings_used;
  int unsigned n_follow;
  int unsigned n_spin;
  int unsigned n_halted;
  int unsigned quiet_cycles;

  // model copy of the registers
  logic [15:0]        cmd_timeout;
  logic [15:0]        sts_timeout;
  logic [15:0]        plan_timeout;
  logic signed [15:0] start_spin;

  // model copy of the state
  logic [AGE_BITS-1:0]        cmd_age;
  logic [AGE_BITS-1:0]        sts_age;
  logic [AGE_BITS-1:0]        plan_age;
  logic                       sts_seen;
  logic                       run_on;
  logic                       stop_on;
  logic                       cmd_held;
  logic signed [VEL_BITS-1:0] held_x;
  logic signed [VEL_BITS-1:0] held_y;
  logic signed [VEL_BITS-1:0] held_rate;
  logic                       spin_seen;
  logic signed [VEL_BITS-1:0] spin_now;
  logic [ANGLE_BITS-1:0]      yaw_now;

  // arctangent of 2^-i, 2^32 per turn
  longint atan_turn [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [AGE_BITS-1:0] age_step(input logic [AGE_BITS-1:0] a);
    return (a == AGE_SAT) ? a : a + 1'b1;
  endfunction

  function automatic logic signed [VEL_BITS-1:0] clamp_vel(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (VEL_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[VEL_BITS-1:0];
    if (v < lo) return lo[VEL_BITS-1:0];
    return v[VEL_BITS-1:0];
  endfunction

  function automatic bit motion_ok();
    return sts_seen && (sts_age <= sts_timeout) && run_on && !stop_on;
  endfunction

  function automatic void drop_held();
    cmd_held  = 1'b0;
    held_x    = '0;
    held_y    = '0;
    held_rate = '0;
  endfunction

  // cos and sin in Q1.30: quadrant folded out, 30 micro-rotations, folded back
  function automatic void yaw_cos_sin(input logic [ANGLE_BITS-1:0] yaw,
                                      output longint c, output longint s);
    logic [31:0] a;
    logic [31:0] t;
    logic [31:0] d;
    logic [1:0]  q;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    int          i;
    a = {yaw, {(32 - ANGLE_BITS){1'b0}}};
    t = a + 32'h2000_0000;
    q = t[31:30];
    d = a - {q, 30'd0};
    z = longint'($signed(d));
    x = 652032874;
    y = 0;
    for (i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn[i];
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // advance the model by one event; returns 1 when a drive word is due
  function automatic bit rotator_step(input event_t ev, output drive_t word);
    longint c;
    longint s;
    longint hx;
    longint hy;
    longint spin;
    word = '0;
    case (ev.mode)
      MODE_COMMAND: begin
        if ((ev.vel_x == 0 && ev.vel_y == 0 && ev.turn_rate == 0) || !motion_ok()) begin
          drop_held();
        end else begin
          cmd_held  = 1'b1;
          held_x    = ev.vel_x;
          held_y    = ev.vel_y;
          held_rate = ev.turn_rate;
          cmd_age   = '0;
        end
        return 1'b0;
      end
      MODE_STATUS: begin
        sts_seen = 1'b1;
        sts_age  = '0;
        run_on   = ev.flag;
        if (!ev.flag) drop_held();
        return 1'b0;
      end
      MODE_STOP: begin
        stop_on = ev.flag;
        if (ev.flag) drop_held();
        return 1'b0;
      end
      MODE_SPIN: begin
        spin_seen = 1'b1;
        spin_now  = ev.turn_rate;
        return 1'b0;
      end
      MODE_YAW: begin
        if (plan_age > plan_timeout) yaw_now = ev.yaw_angle;
        return 1'b0;
      end
      MODE_PLAN: begin
        plan_age = '0;
        return 1'b0;
      end
      MODE_SYNCED: begin
        yaw_now = ev.yaw_angle;
        return 1'b0;
      end
      default: begin
      end
    endcase

    // tick: ages move before any publish
    cmd_age  = age_step(cmd_age);
    sts_age  = age_step(sts_age);
    plan_age = age_step(plan_age);
    if (!ev.flag) return 1'b0;

    spin = spin_seen ? longint'(spin_now) : longint'(start_spin);
    word.frame_angle = '0 - yaw_now;
    if (!motion_ok()) begin
      drop_held();
      word.drive_status = DRIVE_HALTED;
    end else if (cmd_held && cmd_age <= cmd_timeout) begin
      yaw_cos_sin(yaw_now, c, s);
      hx = held_x;
      hy = held_y;
      word.vel_x        = clamp_vel((hx * c + hy * s + (longint'(1) <<< 29)) >>> 30);
      word.vel_y        = clamp_vel((hy * c - hx * s + (longint'(1) <<< 29)) >>> 30);
      word.turn_rate    = clamp_vel(longint'(held_rate) + spin);
      word.drive_status = DRIVE_FOLLOW;
    end else begin
      drop_held();
      word.turn_rate    = clamp_vel(spin);
      word.drive_status = DRIVE_SPIN;
    end
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_COMMAND_TIMEOUT: cmd_timeout  = val;
      CFG_STATUS_TIMEOUT:  sts_timeout  = val;
      CFG_PLANNER_TIMEOUT: plan_timeout = val;
      CFG_INITIAL_SPIN:    start_spin   = $signed(val);
      default: begin
      end
    endcase
  endfunction

  function automatic void note_field(input string name, input longint want,
                                     input longint got);
    if (want != got) begin
      errors++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      end
    end
  endfunction

  // event driver: changes on the falling edge
  always @(negedge clk) begin : drive_events
    event_t nxt;
    if (rst) begin
      ev_ch.valid <= 1'b0;
    end else if (!ev_ch.valid || event_taken) begin
      if (event_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = event_feed.pop_front();
        ev_ch.valid     <= 1'b1;
        ev_ch.mode      <= nxt.mode;
        ev_ch.vel_x     <= nxt.vel_x;
        ev_ch.vel_y     <= nxt.vel_y;
        ev_ch.turn_rate <= nxt.turn_rate;
        ev_ch.yaw_angle <= nxt.yaw_angle;
        ev_ch.flag      <= nxt.flag;
      end else begin
        ev_ch.valid <= 1'b0;
      end
    end
  end

  // drive word receiver
  always @(negedge clk) begin
    if (rst) drive_ch.ready <= 1'b0;
    else     drive_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: model update on accepted events, check of accepted words
  always @(posedge clk) begin : watch_ports
    event_t got_ev;
    drive_t got_w;
    drive_t want_w;
    event_taken = ev_ch.valid && ev_ch.ready;
    if (!rst) begin
      if (reg_ch.valid && reg_ch.ready) begin
        apply_reg(reg_ch.index, reg_ch.data);
        regs_written++;
      end
      if (event_taken) begin
        got_ev.mode      = ev_ch.mode;
        got_ev.vel_x     = ev_ch.vel_x;
        got_ev.vel_y     = ev_ch.vel_y;
        got_ev.turn_rate = ev_ch.turn_rate;
        got_ev.yaw_angle = ev_ch.yaw_angle;
        got_ev.flag      = ev_ch.flag;
        events_accepted++;
        if (rotator_step(got_ev, want_w)) drive_due.push_back(want_w);
      end
      if (drive_ch.valid && drive_ch.ready) begin
        got_w.vel_x        = drive_ch.out_vel_x;
        got_w.vel_y        = drive_ch.out_vel_y;
        got_w.turn_rate    = drive_ch.out_turn_rate;
        got_w.frame_angle  = drive_ch.frame_angle;
        got_w.drive_status = drive_ch.drive_status;
        if (drive_due.size() == 0) begin
          errors++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t drive word with nothing expected: status %0d", $time,
                     got_w.drive_status);
          end
        end else begin
          want_w = drive_due.pop_front();
          note_field("out_vel_x", want_w.vel_x, got_w.vel_x);
          note_field("out_vel_y", want_w.vel_y, got_w.vel_y);
          note_field("out_turn_rate", want_w.turn_rate, got_w.turn_rate);
          note_field("frame_angle", want_w.frame_angle, got_w.frame_angle);
          note_field("drive_status", want_w.drive_status, got_w.drive_status);
          case (want_w.drive_status)
            DRIVE_FOLLOW: n_follow++;
            DRIVE_SPIN:   n_spin++;
            default:      n_halted++;
          endcase
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (ev_ch.valid && ev_ch.ready) || (drive_ch.valid && drive_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic event_t make_event(input logic [MODE_W-1:0] m,
                                        input logic [15:0] vx, input logic [15:0] vy,
                                        input logic [15:0] vr, input logic [15:0] yaw,
                                        input logic f);
    event_t e;
    e.mode      = m;
    e.vel_x     = vx;
    e.vel_y     = vy;
    e.turn_rate = vr;
    e.yaw_angle = yaw;
    e.flag      = f;
    return e;
  endfunction

  // velocity word: mostly random, some extremes, some small
  function automatic logic [15:0] pick_vel();
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    if (k < 3) return 16'($urandom_range(0, 2047)) - 16'd1024;
    return 16'($urandom());
  endfunction

  // yaw word: quadrant boundaries now and then
  function automatic logic [15:0] pick_yaw();
    if ($urandom_range(0, 7) == 0) return 16'h2000 * 16'($urandom_range(0, 7))
                                          - 16'($urandom_range(0, 1));
    return 16'($urandom());
  endfunction

  function automatic logic coin(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic push_ev(input logic [MODE_W-1:0] m, input logic [15:0] vx,
                         input logic [15:0] vy, input logic [15:0] vr,
                         input logic [15:0] yaw, input logic f);
    event_feed.push_back(make_event(m, vx, vy, vr, yaw, f));
  endtask

  // mostly well-formed traffic with random content, plus some noise
  task automatic queue_traffic(input int unsigned count);
    int unsigned n;
    int unsigned r;
    int unsigned k;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // run status, a command, then a few ticks
        push_ev(MODE_STATUS, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(92));
        push_ev(MODE_COMMAND, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(50));
        k = $urandom_range(1, 3);
        n += 2 + k;
        repeat (k) push_ev(MODE_TICK, pick_vel(), pick_vel(), pick_vel(), pick_yaw(),
                           coin(65));
      end else begin
        n++;
        if (r < 40)
          push_ev(MODE_TICK, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(60));
        else if (r < 53)
          if (coin(10)) push_ev(MODE_COMMAND, '0, '0, '0, pick_yaw(), coin(50));
          else push_ev(MODE_COMMAND, pick_vel(), pick_vel(), pick_vel(), pick_yaw(),
                       coin(50));
        else if (r < 59)
          push_ev(MODE_STATUS, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(85));
        else if (r < 65)
          push_ev(MODE_STOP, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(25));
        else if (r < 71)
          push_ev(MODE_SPIN, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(50));
        else if (r < 80)
          push_ev(MODE_YAW, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(50));
        else if (r < 85)
          push_ev(MODE_PLAN, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(50));
        else if (r < 93)
          push_ev(MODE_SYNCED, pick_vel(), pick_vel(), pick_vel(), pick_yaw(), coin(50));
        else
          push_ev(MODE_W'($urandom_range(0, 7)), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), coin(50));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk); while (!reg_ch.ready);
  endtask

  // full register setting, plus one write to an unused index
  task automatic load_regs(input logic [15:0] cmd_to, input logic [15:0] sts_to,
                           input logic [15:0] plan_to, input logic [15:0] spin0);
    write_reg(CFG_COMMAND_TIMEOUT, cmd_to);
    write_reg(CFG_STATUS_TIMEOUT, sts_to);
    write_reg(CFG_PLANNER_TIMEOUT, plan_to);
    write_reg(CFG_INITIAL_SPIN, spin0);
    write_reg(CFG_FIRST_SPARE + CFG_INDEX_W'($urandom_range(0, 251)), 16'($urandom()));
    @(negedge clk);
    reg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // wait until every event is taken and every word has come back
  task automatic drain_phase();
    do @(posedge clk);
    while (event_feed.size() != 0 || ev_ch.valid || drive_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : run_test
    int unsigned ph;
    ev_ch.valid     = 1'b0;
    ev_ch.mode      = MODE_TICK;
    ev_ch.vel_x     = '0;
    ev_ch.vel_y     = '0;
    ev_ch.turn_rate = '0;
    ev_ch.yaw_angle = '0;
    ev_ch.flag      = 1'b0;
    drive_ch.ready  = 1'b0;
    reg_ch.valid    = 1'b0;
    reg_ch.index    = CFG_COMMAND_TIMEOUT;
    reg_ch.data     = '0;
    event_taken     = 1'b0;
    errors          = 0;
    shown           = 0;
    events_accepted = 0;
    regs_written    = 0;
    settings_used   = 1;
    n_follow        = 0;
    n_spin          = 0;
    n_halted        = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 28;
    recv_idle_pct   = 63;

    cmd_timeout  = COMMAND_TIMEOUT_RST;
    sts_timeout  = STATUS_TIMEOUT_RST;
    plan_timeout = PLANNER_TIMEOUT_RST;
    start_spin   = INITIAL_SPIN_RST;
    cmd_age      = AGE_SAT;
    sts_age      = AGE_SAT;
    plan_age     = AGE_SAT;
    sts_seen     = 1'b0;
    run_on       = 1'b0;
    stop_on      = 1'b0;
    spin_seen    = 1'b0;
    drop_held();
    spin_now     = '0;
    yaw_now      = '0;

    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values: gating, rotation and drop rules
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_YAW, '0, '0, '0, 16'h1234, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b0);
    push_ev(MODE_COMMAND, 16'd1000, 16'd2000, 16'd300, '0, 1'b0);
    push_ev(MODE_STATUS, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_COMMAND, 16'h7FFF, 16'h8000, 16'h7FFF, '0, 1'b1);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_SYNCED, '0, '0, '0, 16'hE000, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_COMMAND, '0, '0, '0, '0, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_COMMAND, 16'h8000, 16'h8000, 16'h8000, '0, 1'b0);
    push_ev(MODE_SYNCED, '0, '0, '0, 16'h8000, 1'b1);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_STOP, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_STOP, '0, '0, '0, '0, 1'b0);
    push_ev(MODE_STATUS, '0, '0, '0, '0, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    drain_phase();

    // long command and planner windows, short status window, spin from register
    load_regs(16'hFFFF, 16'd3, 16'hFFFF, 16'h8000);
    push_ev(MODE_STATUS, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_YAW, '0, '0, '0, 16'h4000, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b0);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    drain_phase();

    // zero windows: status goes stale on the first tick
    load_regs(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    push_ev(MODE_STATUS, '0, '0, '0, '0, 1'b1);
    push_ev(MODE_TICK, '0, '0, '0, '0, 1'b1);
    drain_phase();

    // random phases, idle mix changes every two phases
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 63;
        recv_idle_pct = 28;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 3)
        load_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'($urandom()));
      else
        load_regs(16'($urandom_range(1, 30)), 16'($urandom_range(4, 60)),
                  16'($urandom_range(0, 12)), 16'($urandom()));
      queue_traffic(PHASE_EVENTS);
      drain_phase();
    end

    if (drive_due.size() != 0) begin
      errors += drive_due.size();
      $display("%0d expected drive words never arrived", drive_due.size());
    end

    $display("Drove %0d events under %0d register settings (%0d register writes).",
             events_accepted, settings_used, regs_written);
    $display("Checked %0d drive words: %0d following, %0d spin only, %0d halted.",
             n_follow + n_spin + n_halted, n_follow, n_spin, n_halted);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
